@@ rtl/swmf_pkg.sv @@
// ============================================================================
// swmf_pkg
// Shared types and constants of the square window median filter: frame and
// window limits, line store geometry, control enums and inter-module structs.
// ============================================================================
package swmf_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int MAX_SIDE    = 19;
	localparam int STORE_DEPTH = MAX_SIDE * MAX_WIDTH;

	localparam int POS_W   = $clog2(MAX_WIDTH);
	localparam int DIM_W   = 9;
	localparam int SIDE_W  = 5;
	localparam int HALF_W  = 4;
	localparam int PIX_W   = 8;
	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int LIN_W   = 16;
	localparam int CNT_W   = 17;
	localparam int ELEM_W  = 9;
	localparam int PADDR_W = 4;

	// Restoring reduction constants for the store address modulo
	localparam logic [LIN_W-1:0] MOD_X8 = LIN_W'(STORE_DEPTH * 8);
	localparam logic [LIN_W-1:0] MOD_X4 = LIN_W'(STORE_DEPTH * 4);
	localparam logic [LIN_W-1:0] MOD_X2 = LIN_W'(STORE_DEPTH * 2);
	localparam logic [LIN_W-1:0] MOD_X1 = LIN_W'(STORE_DEPTH);

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_WINDOW_SIDE  = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	typedef enum logic [2:0] {
		T_IDLE,
		T_NEED,
		T_CMP,
		T_RUN,
		T_DELIVER
	} top_state_t;

	typedef enum logic [2:0] {
		E_IDLE,
		E_ISSUE,
		E_FLUSH,
		E_BIT,
		E_DONE
	} eng_state_t;

	typedef struct packed {
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [SIDE_W-1:0] side;
		logic [HALF_W-1:0] half;
	} geom_t;

	typedef struct packed {
		logic              start;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
	} eng_cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  data;
	} store_wr_t;

	typedef struct packed {
		logic              done;
		logic [PIX_W-1:0]  median;
	} eng_status_t;

endpackage

@@ rtl/swmf_engine.sv @@
// ============================================================================
// swmf_engine
// Line store plus bit-serial radix median: eight passes over the window, one
// result bit per pass, window addresses streamed through a mirror/multiply/
// modulo pipeline into the store.
// ============================================================================
module swmf_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swmf_pkg::geom_t       geom,
	input  swmf_pkg::eng_cmd_t    cmd,
	input  swmf_pkg::store_wr_t   wr,
	output swmf_pkg::eng_status_t status
);
	import swmf_pkg::*;

	eng_state_t state_q, state_d;

	logic [SIDE_W-1:0] dr_q, dc_q;
	logic [POS_W-1:0]  row_q, col_q;
	logic [PIX_W-1:0]  prefix_q, bsel_q, hmask_q;
	logic [ELEM_W-1:0] k_q, cnt_q;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [POS_W-1:0]  y_s1, x_s1;
	logic [LIN_W-1:0]  lin_s2, a_s3, a_s4, a_s5;
	logic [ADDR_W-1:0] addr_s6;
	logic [PIX_W-1:0]  rd_s7;

	logic [PIX_W-1:0]  store [STORE_DEPTH];

	logic              load, issue, decide, last_elem, pipe_empty, match;
	logic [2*SIDE_W-1:0] total;
	logic signed [10:0]  n_row, n_col;
	logic [2*DIM_W-1:0]  lin_full;

	function automatic logic [POS_W-1:0] mirror(logic signed [10:0] n, logic [DIM_W-1:0] dim);
		logic signed [11:0] m;
		logic signed [11:0] d;
		d = $signed({3'b000, dim});
		m = {n[10], n};
		if (m < 12'sd0) begin
			m = -m - 12'sd1;
		end else if (m >= d) begin
			m = d + d - 12'sd1 - m;
		end
		if (m < 12'sd0) begin
			m = 12'sd0;
		end
		if (m >= d) begin
			m = d - 12'sd1;
		end
		return m[POS_W-1:0];
	endfunction

	function automatic logic [LIN_W-1:0] mod_step(logic [LIN_W-1:0] a, logic [LIN_W-1:0] m);
		return (a >= m) ? a - m : a;
	endfunction

	assign total      = {{SIDE_W{1'b0}}, geom.side} * {{SIDE_W{1'b0}}, geom.side};
	assign last_elem  = (dr_q == geom.side - 5'd1) && (dc_q == geom.side - 5'd1);
	assign pipe_empty = !(v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | v_s7);
	assign match      = (((rd_s7 ^ prefix_q) & hmask_q) == '0) && ((rd_s7 & bsel_q) == '0);

	assign n_row = $signed({3'b000, row_q}) + $signed({6'b0, dr_q}) - $signed({7'b0, geom.half});
	assign n_col = $signed({3'b000, col_q}) + $signed({6'b0, dc_q}) - $signed({7'b0, geom.half});
	assign lin_full = {{(DIM_W+1){1'b0}}, y_s1} * {{DIM_W{1'b0}}, geom.width}
		+ {{(DIM_W+1){1'b0}}, x_s1};

	always_comb begin
		state_d = state_q;
		case (state_q)
			E_IDLE:  if (cmd.start) state_d = E_ISSUE;
			E_ISSUE: if (last_elem) state_d = E_FLUSH;
			E_FLUSH: if (pipe_empty) state_d = E_BIT;
			E_BIT:   state_d = bsel_q[0] ? E_DONE : E_ISSUE;
			E_DONE:  state_d = E_IDLE;
			default: state_d = E_IDLE;
		endcase
	end

	always_comb begin
		load          = 1'b0;
		issue         = 1'b0;
		decide        = 1'b0;
		status.done   = 1'b0;
		status.median = prefix_q;
		case (state_q)
			E_IDLE:  load = cmd.start;
			E_ISSUE: issue = 1'b1;
			E_BIT:   decide = 1'b1;
			E_DONE:  status.done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			dr_q <= '0;
			dc_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			if (load || decide) begin
				dr_q  <= '0;
				dc_q  <= '0;
				cnt_q <= '0;
			end else begin
				if (issue) begin
					if (dc_q == geom.side - 5'd1) begin
						dc_q <= '0;
						dr_q <= dr_q + 5'd1;
					end else begin
						dc_q <= dc_q + 5'd1;
					end
				end
				if (v_s7 && match) begin
					cnt_q <= cnt_q + 9'd1;
				end
			end
		end
	end

	// Radix state: hold rank, prefix and bit masks across passes
	always_ff @(posedge clk) begin
		if (load) begin
			row_q    <= cmd.row;
			col_q    <= cmd.col;
			k_q      <= {1'b0, total[ELEM_W-1:1]};
			prefix_q <= '0;
			bsel_q   <= 8'h80;
			hmask_q  <= '0;
		end else if (decide) begin
			if (k_q >= cnt_q) begin
				prefix_q <= prefix_q | bsel_q;
				k_q      <= k_q - cnt_q;
			end
			bsel_q  <= {1'b0, bsel_q[PIX_W-1:1]};
			hmask_q <= {1'b1, hmask_q[PIX_W-1:1]};
		end
	end

	// Address pipeline and store
	always_ff @(posedge clk) begin
		y_s1    <= mirror(n_row, geom.height);
		x_s1    <= mirror(n_col, geom.width);
		lin_s2  <= lin_full[LIN_W-1:0];
		a_s3    <= mod_step(lin_s2, MOD_X8);
		a_s4    <= mod_step(a_s3, MOD_X4);
		a_s5    <= mod_step(a_s4, MOD_X2);
		addr_s6 <= ADDR_W'(mod_step(a_s5, MOD_X1));
		if (wr.en) begin
			store[wr.addr] <= wr.data;
		end
		rd_s7 <= store[addr_s6];
	end

endmodule

@@ rtl/square_window_median_filter_top.sv @@
// ============================================================================
// square_window_median_filter_top
// Streaming 2-D median filter over an odd square window with mirrored
// borders, raster-order 8-bit pixels in, raster-order medians out.
// ============================================================================
//
//  channel   handshake                  payload
//  -------   -------------------------  ------------------------------------
//  input     in_valid / in_ready        pixel_value[7:0], drain
//  output    out_valid / out_ready      median_value[7:0], end_of_frame
//  config    psel, penable, pwrite      paddr[3:0], pwdata[31:0], prdata
//
//  Flow: an accepted item passes the need and compare states; when a median
//  becomes due, the engine runs 8 radix passes, each streaming the window
//  through the 7-stage address/store pipeline, draining it and deciding one
//  bit.
//  Reset: positions clear, registers return to side 3, 256 x 256; the line
//  store is not cleared and needs no clearing pass.
//  Stalls: a finished median waits in the output register while the next
//  item is taken; a new median waits in med_q until that register frees.
//
module square_window_median_filter_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swmf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  pixel_value,
	input  logic                        drain,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  median_value,
	output logic                        end_of_frame
);
	import swmf_pkg::*;

	top_state_t state_q, state_d;

	// Configuration registers (raw) and their effective values
	logic [SIDE_W-1:0] side_raw_q;
	logic [DIM_W-1:0]  width_raw_q, height_raw_q;
	logic [SIDE_W-1:0] side_clip;
	geom_t             geom;

	// Frame positions
	logic [DIM_W-1:0]  in_row_q;
	logic [POS_W-1:0]  in_col_q;
	logic [POS_W-1:0]  out_row_q, out_col_q;
	logic [CNT_W-1:0]  count_q, need_q;
	logic [ADDR_W-1:0] wp_q;

	logic [DIM_W-1:0]  nr, nc;
	logic [2*DIM_W-1:0] need_full;

	logic              cfg_wr, accept, pix_wr, eof;
	logic              start, deliver;
	logic [PIX_W-1:0]  med_q;
	logic              out_valid_q, eof_q;
	logic [PIX_W-1:0]  out_med_q;

	eng_cmd_t          cmd;
	store_wr_t         wr;
	eng_status_t       status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_WINDOW_SIDE:  prdata = {27'b0, side_raw_q};
			REG_IMAGE_WIDTH:  prdata = {23'b0, width_raw_q};
			REG_IMAGE_HEIGHT: prdata = {23'b0, height_raw_q};
			default:          prdata = '0;
		endcase
	end

	// Clip the registers: zero acts as one, oversize saturates, even side drops to odd
	always_comb begin
		geom.width  = (width_raw_q == '0) ? 9'd1
			: (width_raw_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_raw_q;
		geom.height = (height_raw_q == '0) ? 9'd1
			: (height_raw_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_raw_q;
		side_clip   = (side_raw_q == '0) ? 5'd1
			: (side_raw_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_raw_q;
		geom.side   = side_clip[0] ? side_clip : side_clip - 5'd1;
		geom.half   = geom.side[SIDE_W-1:1];
	end

	// Last window row and column that the next output needs, clamped to the frame
	always_comb begin
		nr = {1'b0, out_row_q} + {5'b0, geom.half};
		if (nr > geom.height - 9'd1) nr = geom.height - 9'd1;
		nc = {1'b0, out_col_q} + {5'b0, geom.half};
		if (nc > geom.width - 9'd1) nc = geom.width - 9'd1;
	end
	assign need_full = {9'b0, nr} * {9'b0, geom.width} + {9'b0, nc};

	assign accept = in_valid && in_ready;
	assign pix_wr = accept && !drain && (in_row_q < geom.height);
	assign eof    = ({1'b0, out_row_q} == geom.height - 9'd1)
		&& ({1'b0, out_col_q} == geom.width - 9'd1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE:    if (accept) state_d = T_NEED;
			T_NEED:    state_d = T_CMP;
			T_CMP:     state_d = (need_q < count_q) ? T_RUN : T_IDLE;
			T_RUN:     if (status.done) state_d = T_DELIVER;
			T_DELIVER: if (!out_valid_q || out_ready) state_d = T_IDLE;
			default:   state_d = T_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		start    = 1'b0;
		deliver  = 1'b0;
		case (state_q)
			T_IDLE:    in_ready = 1'b1;
			T_CMP:     start = (need_q < count_q);
			T_DELIVER: deliver = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	assign cmd.start = start;
	assign cmd.row   = out_row_q;
	assign cmd.col   = out_col_q;
	assign wr.en     = pix_wr;
	assign wr.addr   = wp_q;
	assign wr.data   = pixel_value;

	swmf_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.geom   (geom),
		.cmd    (cmd),
		.wr     (wr),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			side_raw_q   <= 5'd3;
			width_raw_q  <= 9'd256;
			height_raw_q <= 9'd256;
			in_row_q     <= '0;
			in_col_q     <= '0;
			out_row_q    <= '0;
			out_col_q    <= '0;
			count_q      <= '0;
			wp_q         <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr && (paddr[3:2] != 2'd3)) begin
				// Any register write abandons the frame in progress
				case (paddr[3:2])
					REG_WINDOW_SIDE:  side_raw_q   <= pwdata[SIDE_W-1:0];
					REG_IMAGE_WIDTH:  width_raw_q  <= pwdata[DIM_W-1:0];
					REG_IMAGE_HEIGHT: height_raw_q <= pwdata[DIM_W-1:0];
					default:          ;
				endcase
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
				count_q   <= '0;
				wp_q      <= '0;
			end
			if (pix_wr) begin
				count_q <= count_q + 17'd1;
				wp_q    <= (wp_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wp_q + 13'd1;
				if ({1'b0, in_col_q} + 9'd1 >= geom.width) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 9'd1;
				end else begin
					in_col_q <= in_col_q + 8'd1;
				end
			end
			if (deliver) begin
				out_valid_q <= 1'b1;
				if (eof) begin
					// Frame complete: restart every position
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					count_q   <= '0;
					wp_q      <= '0;
				end else if ({1'b0, out_col_q} + 9'd1 >= geom.width) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 8'd1;
				end else begin
					out_col_q <= out_col_q + 8'd1;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == T_NEED) begin
			need_q <= need_full[CNT_W-1:0];
		end
		if (status.done) begin
			med_q <= status.median;
		end
		if (deliver) begin
			out_med_q <= med_q;
			eof_q     <= eof;
		end
	end

	assign out_valid    = out_valid_q;
	assign median_value = out_med_q;
	assign end_of_frame = eof_q;

endmodule
